/* hw/rtl/crcfm_pkg.sv */
// ----------------------------------------------------------------------------
// crcfm_pkg: shared types and constants of the framed message checker
// Configuration codes, frame geometry, CRC constants and the structs that
// pass header, configuration and result data between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfm_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_START_MARKER   = 4'd0;
  localparam logic [3:0] CFG_VERSION_MARKER = 4'd1;
  localparam logic [3:0] CFG_TAGGED_TYPE    = 4'd2;
  localparam logic [3:0] CFG_TAG_BYTES      = 4'd3;

  localparam logic [7:0] START_MARKER_RST   = 8'h4F;
  localparam logic [7:0] VERSION_MARKER_RST = 8'h02;
  localparam logic [7:0] TAGGED_TYPE_RST    = 8'h04;
  localparam logic [5:0] TAG_BYTES_RST      = 6'd8;

  // Frame geometry, in byte positions
  localparam logic [16:0] HDR_LEN   = 17'd17;
  localparam logic [16:0] MIN_LEN   = 17'd19;
  localparam logic [16:0] REQ_END   = 17'd21;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    VERDICT_OK           = 3'd0,
    VERDICT_SHORT        = 3'd1,
    VERDICT_BAD_MARKER   = 3'd2,
    VERDICT_TRUNCATED    = 3'd3,
    VERDICT_CRC_MISMATCH = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] version_marker;
    logic [7:0] tagged_type;
    logic [5:0] tag_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  type_code;
    logic [7:0]  command;
    logic [15:0] sequence_num;
    logic [15:0] length;
    logic [7:0]  status;
    logic [63:0] stamp;
  } hdr_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  pay_byte;
    logic [15:0] pay_index;
    hdr_t        hdr;
    logic [31:0] request_id;
    verdict_e    verdict;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/crc_framed_message_checker.sv */
// ----------------------------------------------------------------------------
// crc_framed_message_checker: CRC-16 framed message deframer and checker
// Input register, per-message parse logic and output register; one byte per
// cycle in when not stalled, at most one payload byte or verdict out per byte.
// ----------------------------------------------------------------------------
// The checker takes one message byte per clock cycle when neither side
// stalls; a byte is captured into the input register and parsed there, and
// its result (if any) is loaded into the output register when the byte
// advances, which waits while a held result is stalled at the output. The
// rate is set by the combinational path from the input register through
// the bytewise CRC update and the expected-length compare into the message
// state. Messages are a 17-byte big-endian header, length payload bytes, an
// optional tag (when the type equals tagged_type) and a 2-byte CRC. Payload
// bytes stream out as soon as both marker bytes match; the byte with
// last_flag set yields one verdict carrying the captured header fields.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write them only while no message is in flight, which the
// block itself does not enforce; unknown indexes are ignored.
`default_nettype none

module crc_framed_message_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_flag_i,
  input  logic        last_flag_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  message_type_o,
  output logic [7:0]  command_code_o,
  output logic [15:0] sequence_number_o,
  output logic [15:0] length_field_o,
  output logic [7:0]  status_byte_o,
  output logic [63:0] time_stamp_o,
  output logic [31:0] request_id_o,
  output logic [2:0]  verdict_o
);

  crcfm_pkg::cfg_t cfg_q;

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_first_q;
  logic            in_last_q;

  logic            out_valid_q;
  crcfm_pkg::res_t out_q;

  crcfm_pkg::res_t res;
  logic            advance;

  // Configuration registers: decode the index, drop unknown ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker   <= crcfm_pkg::START_MARKER_RST;
      cfg_q.version_marker <= crcfm_pkg::VERSION_MARKER_RST;
      cfg_q.tagged_type    <= crcfm_pkg::TAGGED_TYPE_RST;
      cfg_q.tag_bytes      <= crcfm_pkg::TAG_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crcfm_pkg::CFG_START_MARKER:   cfg_q.start_marker   <= cfg_data_i;
        crcfm_pkg::CFG_VERSION_MARKER: cfg_q.version_marker <= cfg_data_i;
        crcfm_pkg::CFG_TAGGED_TYPE:    cfg_q.tagged_type    <= cfg_data_i;
        crcfm_pkg::CFG_TAG_BYTES:      cfg_q.tag_bytes      <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Advance the held byte whenever the output register is free or draining.
  // A byte that yields no result advances as well.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register: load a new request, otherwise drop the consumed one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= data_byte_i;
      in_first_q <= first_flag_i;
      in_last_q  <= last_flag_i;
    end
  end

  crcfm_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .first_i   (in_first_q),
    .last_i    (in_last_q),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  // Output register: take the new result, or clear once the old one is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign item_kind_o       = out_q.kind;
  assign payload_byte_o    = out_q.pay_byte;
  assign payload_index_o   = out_q.pay_index;
  assign message_type_o    = out_q.hdr.type_code;
  assign command_code_o    = out_q.hdr.command;
  assign sequence_number_o = out_q.hdr.sequence_num;
  assign length_field_o    = out_q.hdr.length;
  assign status_byte_o     = out_q.hdr.status;
  assign time_stamp_o      = out_q.hdr.stamp;
  assign request_id_o      = out_q.request_id;
  assign verdict_o         = out_q.verdict;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !advance)
    else $error("pending result overwritten");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.valid |=> out_valid_q)
    else $error("result lost between stages");

endmodule

`default_nettype wire

/* hw/rtl/crcfm_crc16.sv */
// ----------------------------------------------------------------------------
// crcfm_crc16: bytewise CRC-16/CCITT-FALSE update
// Folds one byte into a running CRC, MSB first, in one combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfm_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ crcfm_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

/* hw/rtl/crcfm_frame.sv */
// ----------------------------------------------------------------------------
// crcfm_frame: per-message parse state and verdict logic
// Holds byte count, CRCs, marker flag and captured header; works out the
// result of one byte and the next message state in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfm_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic [7:0]         byte_i,
  input  logic               first_i,
  input  logic               last_i,
  input  crcfm_pkg::cfg_t    cfg_i,
  output crcfm_pkg::res_t    res_o
);

  logic [16:0]       count_q, count_d;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       body_q, body_d;
  logic [15:0]       rx_q, rx_d;
  logic              bad_q, bad_d;
  crcfm_pkg::hdr_t   hdr_q, hdr_d;
  logic [31:0]       req_q, req_d;

  logic [16:0]       pos;
  logic [15:0]       crc_b;
  logic [15:0]       crc_upd;
  logic [16:0]       cnt_n;

  assign pos   = first_i ? '0 : count_q;
  assign crc_b = first_i ? crcfm_pkg::CRC_INIT : crc_q;

  crcfm_crc16 u_crc (
    .crc_i  (crc_b),
    .byte_i (byte_i),
    .crc_o  (crc_upd)
  );

  always_comb begin
    logic [15:0]     body_b, rx_b, crc_n, body_n, rx_n;
    logic            bad_b, bad_n;
    crcfm_pkg::hdr_t hdr_b, hdr_n;
    logic [31:0]     req_b, req_n;
    logic [16:0]     tag_add, total, total_m1, total_m2, pay_end, idx_full;
    logic            in_payload;

    body_b = first_i ? '0 : body_q;
    rx_b   = first_i ? '0 : rx_q;
    bad_b  = first_i ? 1'b0 : bad_q;
    hdr_b  = first_i ? '0 : hdr_q;
    req_b  = first_i ? '0 : req_q;

    // header capture
    hdr_n = hdr_b;
    bad_n = bad_b;
    if (pos < crcfm_pkg::HDR_LEN) begin
      case (pos[4:0])
        5'd0: if (byte_i != cfg_i.start_marker) bad_n = 1'b1;
        5'd1: if (byte_i != cfg_i.version_marker) bad_n = 1'b1;
        5'd2: hdr_n.type_code = byte_i;
        5'd3: hdr_n.command = byte_i;
        5'd4, 5'd5: hdr_n.sequence_num = {hdr_b.sequence_num[7:0], byte_i};
        5'd6, 5'd7: hdr_n.length = {hdr_b.length[7:0], byte_i};
        5'd8: hdr_n.status = byte_i;
        default: hdr_n.stamp = {hdr_b.stamp[55:0], byte_i};
      endcase
    end

    tag_add  = (hdr_n.type_code == cfg_i.tagged_type) ? {11'd0, cfg_i.tag_bytes} : '0;
    total    = crcfm_pkg::MIN_LEN + {1'b0, hdr_n.length} + tag_add;
    total_m1 = total - 17'd1;
    total_m2 = total - 17'd2;

    // CRC runs over the body, then the trailing two bytes are collected
    crc_n  = crc_b;
    body_n = body_b;
    rx_n   = rx_b;
    if (pos < total_m2) begin
      crc_n = crc_upd;
    end else if (pos == total_m2) begin
      body_n = crc_b;
      rx_n   = {byte_i, 8'h00};
    end else if (pos == total_m1) begin
      rx_n = rx_b | {8'h00, byte_i};
    end

    pay_end    = crcfm_pkg::HDR_LEN + {1'b0, hdr_n.length};
    in_payload = (pos >= crcfm_pkg::HDR_LEN) && (pos < pay_end);
    req_n      = req_b;
    if (in_payload && (pos < crcfm_pkg::REQ_END)) begin
      req_n = {req_b[23:0], byte_i};
    end

    cnt_n    = (pos == crcfm_pkg::COUNT_MAX) ? pos : pos + 17'd1;
    idx_full = pos - crcfm_pkg::HDR_LEN;

    res_o            = '0;
    res_o.hdr        = hdr_n;
    res_o.verdict    = crcfm_pkg::VERDICT_OK;
    if (last_i) begin
      res_o.valid      = 1'b1;
      res_o.kind       = 1'b1;
      res_o.request_id = (hdr_n.length >= 16'd4) ? req_n : '0;
      if (cnt_n < crcfm_pkg::MIN_LEN) begin
        res_o.verdict = crcfm_pkg::VERDICT_SHORT;
      end else if (bad_n) begin
        res_o.verdict = crcfm_pkg::VERDICT_BAD_MARKER;
      end else if (cnt_n < total) begin
        res_o.verdict = crcfm_pkg::VERDICT_TRUNCATED;
      end else if (body_n != rx_n) begin
        res_o.verdict = crcfm_pkg::VERDICT_CRC_MISMATCH;
      end
    end else if (in_payload && !bad_n) begin
      res_o.valid     = 1'b1;
      res_o.pay_byte  = byte_i;
      res_o.pay_index = idx_full[15:0];
    end

    // a verdict returns the message state to its reset value
    if (last_i) begin
      count_d = '0;
      crc_d   = crcfm_pkg::CRC_INIT;
      body_d  = '0;
      rx_d    = '0;
      bad_d   = 1'b0;
      hdr_d   = '0;
      req_d   = '0;
    end else begin
      count_d = cnt_n;
      crc_d   = crc_n;
      body_d  = body_n;
      rx_d    = rx_n;
      bad_d   = bad_n;
      hdr_d   = hdr_n;
      req_d   = req_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= crcfm_pkg::CRC_INIT;
      body_q  <= '0;
      rx_q    <= '0;
      bad_q   <= 1'b0;
      hdr_q   <= '0;
      req_q   <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
      crc_q   <= crc_d;
      body_q  <= body_d;
      rx_q    <= rx_d;
      bad_q   <= bad_d;
      hdr_q   <= hdr_d;
      req_q   <= req_d;
    end
  end

  a_verdict_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last_i |=> (count_q == '0) && (crc_q == crcfm_pkg::CRC_INIT))
    else $error("message state not cleared after verdict");

  a_accept_long_enough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind && (res_o.verdict == crcfm_pkg::VERDICT_OK)
      |-> cnt_n >= crcfm_pkg::MIN_LEN)
    else $error("accepted verdict on a short message");

  a_payload_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.kind |-> (res_o.pay_index < res_o.hdr.length) &&
      (res_o.verdict == crcfm_pkg::VERDICT_OK) && (res_o.request_id == '0))
    else $error("payload result outside payload or with verdict data");

endmodule

`default_nettype wire

/* tb/tb_crc_framed_message_checker.sv */
// ----------------------------------------------------------------------------
// tb_crc_framed_message_checker: self-checking bench of the framed checker
// Drives framed byte messages, both well-formed and broken, through the link
// request channel, predicts every payload byte and verdict with a byte-level
// model of the deframer, and compares each result request field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_crc_framed_message_checker;

  import crcfm_pkg::*;

  // Idle cycles after the last due result before a register write or the end;
  // the block holds just an input byte and an output result, so this is enough.
  localparam int SETTLE_CYCLES  = 8;
  // Cycles without any accepted request before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 3000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int RX_HOLD_CYCLES = 300;

  localparam int HDR_BYTES = int'(HDR_LEN);
  localparam int MIN_BYTES = int'(MIN_LEN);
  localparam int REQ_BYTES_END = int'(REQ_END);

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [3:0] CFG_UNMAPPED = 4'd9;

  typedef enum int {
    FAULT_NONE,
    FAULT_CRC_BIT,
    FAULT_MARKER,
    FAULT_TRUNCATE,
    FAULT_CUT_PAYLOAD,
    FAULT_ABANDON,
    FAULT_SHORT
  } frame_fault_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first_flag;
    logic       last_flag;
  } link_byte_t;

  typedef struct {
    logic        kind;
    logic [7:0]  pay_byte;
    logic [15:0] pay_index;
    hdr_t        hdr;
    logic [31:0] request_id;
    verdict_e    verdict;
  } deframer_output_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [3:0]  cfg_idx_i    = 4'd0;
  logic [7:0]  cfg_data_i   = 8'd0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        first_flag_i = 1'b0;
  logic        last_flag_i  = 1'b0;
  logic        out_stall_i  = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        item_kind_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] payload_index_o;
  logic [7:0]  message_type_o;
  logic [7:0]  command_code_o;
  logic [15:0] sequence_number_o;
  logic [15:0] length_field_o;
  logic [7:0]  status_byte_o;
  logic [63:0] time_stamp_o;
  logic [31:0] request_id_o;
  logic [2:0]  verdict_o;

  always #5 clk_i = ~clk_i;

  crc_framed_message_checker DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .first_flag_i      (first_flag_i),
    .last_flag_i       (last_flag_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .item_kind_o       (item_kind_o),
    .payload_byte_o    (payload_byte_o),
    .payload_index_o   (payload_index_o),
    .message_type_o    (message_type_o),
    .command_code_o    (command_code_o),
    .sequence_number_o (sequence_number_o),
    .length_field_o    (length_field_o),
    .status_byte_o     (status_byte_o),
    .time_stamp_o      (time_stamp_o),
    .request_id_o      (request_id_o),
    .verdict_o         (verdict_o)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  link_byte_t       link_bytes[$];        // bytes still to be offered
  deframer_output_t deframer_outputs[$];  // predicted results, oldest first

  int mismatch_count = 0;
  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int rx_hold_asked  = 0;
  int rx_hold_taken  = 0;
  int rx_hold_left   = 0;
  int quiet_cycles   = 0;

  // Configuration as the block holds it; only the stimulus process writes it.
  logic [7:0] cfg_start   = START_MARKER_RST;
  logic [7:0] cfg_version = VERSION_MARKER_RST;
  logic [7:0] cfg_tagged  = TAGGED_TYPE_RST;
  logic [5:0] cfg_tag     = TAG_BYTES_RST;

  // Message state of the deframer model; only the driver writes it.
  logic [16:0] byte_pos     = '0;
  logic [15:0] crc_run      = CRC_INIT;
  logic [15:0] crc_body     = '0;
  logic [15:0] crc_rx       = '0;
  logic        marker_bad   = 1'b0;
  hdr_t        frame_hdr    = '0;
  logic [31:0] request_word = '0;

  // --------------------------------------------------------------------------
  // Deframer model
  // --------------------------------------------------------------------------
  // CRC-16/CCITT-FALSE, one byte, MSB first.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic clear_frame_state();
    byte_pos     = '0;
    crc_run      = CRC_INIT;
    crc_body     = '0;
    crc_rx       = '0;
    marker_bad   = 1'b0;
    frame_hdr    = '0;
    request_word = '0;
  endtask

  // Advance the model by one accepted byte and queue the result it causes.
  task automatic deframe_byte(input logic [7:0] b, input logic first_flag,
                              input logic last_flag);
    int               pos;
    int               total;
    bit               in_payload;
    deframer_output_t r;
    if (first_flag) clear_frame_state();
    pos = int'(byte_pos);

    // Header capture: markers are only compared, the rest shifts in big endian.
    case (pos)
      0: if (b != cfg_start) marker_bad = 1'b1;
      1: if (b != cfg_version) marker_bad = 1'b1;
      2: frame_hdr.type_code = b;
      3: frame_hdr.command = b;
      4, 5: frame_hdr.sequence_num = {frame_hdr.sequence_num[7:0], b};
      6, 7: frame_hdr.length = {frame_hdr.length[7:0], b};
      8: frame_hdr.status = b;
      default: if (pos < HDR_BYTES) frame_hdr.stamp = {frame_hdr.stamp[55:0], b};
    endcase

    // Expected frame size follows the current registers and header values.
    total = MIN_BYTES + int'(frame_hdr.length) +
            ((frame_hdr.type_code == cfg_tagged) ? int'(cfg_tag) : 0);

    // CRC covers everything before the trailing two bytes; bytes past the
    // frame end leave it alone.
    if (pos < total - 2) begin
      crc_run = crc16_step(crc_run, b);
    end else if (pos == total - 2) begin
      crc_body = crc_run;
      crc_rx   = {b, 8'h00};
    end else if (pos == total - 1) begin
      crc_rx[7:0] = b;
    end

    in_payload = (pos >= HDR_BYTES) && (pos < HDR_BYTES + int'(frame_hdr.length));
    if (in_payload && pos < REQ_BYTES_END) request_word = {request_word[23:0], b};

    if (byte_pos != COUNT_MAX) byte_pos = byte_pos + 17'd1;

    if (last_flag) begin
      r.kind       = 1'b1;
      r.pay_byte   = '0;
      r.pay_index  = '0;
      r.hdr        = frame_hdr;
      r.request_id = (frame_hdr.length >= 16'd4) ? request_word : '0;
      if (byte_pos < MIN_LEN) r.verdict = VERDICT_SHORT;
      else if (marker_bad) r.verdict = VERDICT_BAD_MARKER;
      else if (int'(byte_pos) < total) r.verdict = VERDICT_TRUNCATED;
      else if (crc_body != crc_rx) r.verdict = VERDICT_CRC_MISMATCH;
      else r.verdict = VERDICT_OK;
      deframer_outputs.push_back(r);
      // A verdict ends the message whether or not a first flag follows.
      clear_frame_state();
    end else if (in_payload && !marker_bad) begin
      r.kind       = 1'b0;
      r.pay_byte   = b;
      r.pay_index  = 16'(pos - HDR_BYTES);
      r.hdr        = frame_hdr;
      r.request_id = '0;
      r.verdict    = VERDICT_OK;
      deframer_outputs.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued bytes, hold a stalled request, idle at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_link
    link_byte_t next_byte;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(data_byte_i, first_flag_i, last_flag_i);
      end
      // Keep the payload steady while stalled; otherwise load the next byte.
      // Do not idle during the receiver hold-off so the block fills up.
      if (!in_valid_i || !in_stall_o) begin
        if (link_bytes.size() != 0 &&
            (rx_hold_left != 0 || $urandom_range(0, 99) >= tx_idle_pct)) begin
          next_byte    = link_bytes.pop_front();
          in_valid_i   <= 1'b1;
          data_byte_i  <= next_byte.data;
          first_flag_i <= next_byte.first_flag;
          last_flag_i  <= next_byte.last_flag;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    deframer_output_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (deframer_outputs.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d verdict %0d",
                   $time, item_kind_o, verdict_o);
          mismatch_count++;
        end else begin
          want = deframer_outputs.pop_front();
          check_field("item_kind", want.kind, item_kind_o);
          check_field("payload_byte", want.pay_byte, payload_byte_o);
          check_field("payload_index", want.pay_index, payload_index_o);
          check_field("message_type", want.hdr.type_code, message_type_o);
          check_field("command_code", want.hdr.command, command_code_o);
          check_field("sequence_number", want.hdr.sequence_num, sequence_number_o);
          check_field("length_field", want.hdr.length, length_field_o);
          check_field("status_byte", want.hdr.status, status_byte_o);
          check_field("time_stamp", want.hdr.stamp, time_stamp_o);
          check_field("request_id", want.request_id, request_id_o);
          check_field("verdict", want.verdict, verdict_o);
        end
      end
      // Start a long hold-off when asked, count it down, else stall at random.
      if (rx_hold_asked != rx_hold_taken) begin
        rx_hold_taken <= rx_hold_asked;
        rx_hold_left  <= RX_HOLD_CYCLES;
        out_stall_i   <= 1'b1;
      end else if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_stall_i  <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no request moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
        $display("crc_framed_message_checker verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Build one frame from the current registers, damage it as asked, append
  // trailing bytes and queue it. An abandoned frame gets no last flag.
  task automatic queue_frame(frame_fault_e fault, logic [7:0] frame_type, int len,
                             bit with_first, int trail);
    logic [7:0]  f[$];
    logic [15:0] crc;
    logic [15:0] seq;
    logic [63:0] stamp;
    int          cut;
    int          pos;
    link_byte_t  lb;
    seq   = 16'($urandom);
    stamp = {$urandom, $urandom};
    f.push_back(cfg_start);
    f.push_back(cfg_version);
    f.push_back(frame_type);
    f.push_back(8'($urandom));
    f.push_back(seq[15:8]);
    f.push_back(seq[7:0]);
    f.push_back(8'(len >> 8));
    f.push_back(8'(len));
    f.push_back(8'($urandom));
    for (int k = 7; k >= 0; k--) f.push_back(stamp[8*k +: 8]);
    repeat (len) f.push_back(8'($urandom));
    if (frame_type == cfg_tagged) repeat (cfg_tag) f.push_back(8'($urandom));

    if (fault == FAULT_MARKER) begin
      pos    = $urandom_range(0, 1);
      f[pos] = f[pos] ^ (8'h01 << $urandom_range(0, 7));
    end

    crc = CRC_INIT;
    foreach (f[i]) crc = crc16_step(crc, f[i]);
    f.push_back(crc[15:8]);
    f.push_back(crc[7:0]);

    if (fault == FAULT_CRC_BIT) begin
      pos    = $urandom_range(2, f.size() - 1);
      f[pos] = f[pos] ^ (8'h01 << $urandom_range(0, 7));
    end

    repeat (trail) f.push_back(8'($urandom));

    cut = f.size();
    case (fault)
      FAULT_TRUNCATE:    cut = (f.size() > MIN_BYTES) ?
                               $urandom_range(MIN_BYTES, f.size() - 1) : MIN_BYTES - 1;
      // Land the last flag on a payload byte, with at least the minimum frame sent.
      FAULT_CUT_PAYLOAD: cut = (len >= 2) ?
                               $urandom_range(MIN_BYTES, HDR_BYTES + ((len < 24) ? len : 24)) :
                               MIN_BYTES - 1;
      FAULT_ABANDON:     cut = $urandom_range(1, f.size() - 1);
      FAULT_SHORT:       cut = $urandom_range(1, MIN_BYTES - 1);
      default: ;
    endcase
    while (f.size() > cut) void'(f.pop_back());

    for (int i = 0; i < f.size(); i++) begin
      lb.data       = f[i];
      lb.first_flag = with_first && (i == 0);
      lb.last_flag  = (i == f.size() - 1) && (fault != FAULT_ABANDON);
      link_bytes.push_back(lb);
    end
  endtask

  task automatic queue_lone_byte(logic [7:0] data, logic first_flag, logic last_flag);
    link_byte_t lb;
    lb.data       = data;
    lb.first_flag = first_flag;
    lb.last_flag  = last_flag;
    link_bytes.push_back(lb);
  endtask

  // Frames with random content, about half of them damaged or cut, and loose
  // noise bytes with random flags.
  task automatic queue_random_traffic(int n_bytes);
    int           goal;
    frame_fault_e fault;
    logic [7:0]   frame_type;
    int           len;
    goal = link_bytes.size() + n_bytes;
    while (link_bytes.size() < goal) begin
      if ($urandom_range(0, 99) < 82) begin
        case ($urandom_range(0, 11))
          5:       fault = FAULT_CRC_BIT;
          6:       fault = FAULT_MARKER;
          7:       fault = FAULT_TRUNCATE;
          8:       fault = FAULT_CUT_PAYLOAD;
          9:       fault = FAULT_ABANDON;
          10:      fault = FAULT_SHORT;
          default: fault = FAULT_NONE;
        endcase
        frame_type = ($urandom_range(0, 99) < 40) ? cfg_tagged : 8'($urandom);
        len        = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) :
                                                    $urandom_range(9, 40);
        queue_frame(fault, frame_type, len, $urandom_range(0, 9) != 0,
                    ($urandom_range(0, 99) < 15) ? $urandom_range(1, 4) : 0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_lone_byte(8'($urandom), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 99) < 30);
        end
      end
    end
  endtask

  // Hold the sender until every byte went out and every result came back,
  // then let the pipeline drain bytes that cause no result.
  task automatic wait_quiet();
    while (link_bytes.size() != 0 || in_valid_i || deframer_outputs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_START_MARKER:   cfg_start   = value;
      CFG_VERSION_MARKER: cfg_version = value;
      CFG_TAGGED_TYPE:    cfg_tagged  = value;
      CFG_TAG_BYTES:      cfg_tag     = value[5:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase 1: reset registers, sender rarely idles, receiver stalls often.
    tx_idle_pct = 6;
    rx_idle_pct = 53;

    // Bytes before any first flag form a message from position 0.
    queue_frame(FAULT_NONE, 8'h00, 0, 1'b0, 0);
    queue_frame(FAULT_NONE, cfg_tagged, 4, 1'b1, 0);
    // After a verdict the next byte starts a message even with no first flag;
    // a payload shorter than four bytes yields no request id.
    queue_frame(FAULT_NONE, 8'hFF, 3, 1'b0, 0);
    queue_lone_byte(8'hFF, 1'b1, 1'b1);
    queue_lone_byte(8'h00, 1'b1, 1'b1);
    queue_frame(FAULT_MARKER, 8'h5A, 2, 1'b1, 0);
    // Maximum length field, cut short with the last flag on a payload byte.
    queue_frame(FAULT_CUT_PAYLOAD, 8'h01, 65535, 1'b1, 0);
    queue_frame(FAULT_CRC_BIT, 8'h11, 5, 1'b1, 0);
    // Bytes past the expected total are counted but otherwise ignored.
    queue_frame(FAULT_NONE, 8'h22, 1, 1'b1, 3);
    queue_frame(FAULT_ABANDON, cfg_tagged, 6, 1'b1, 0);
    queue_frame(FAULT_NONE, cfg_tagged, 9, 1'b1, 0);
    queue_frame(FAULT_TRUNCATE, 8'h80, 7, 1'b1, 0);

    queue_random_traffic(30);

    // Hold off the receiver while the sender keeps offering.
    while (link_bytes.size() > 80) @(posedge clk_i);
    rx_hold_asked = rx_hold_asked + 1;
    wait_quiet();

    // Phase 2: random markers, longest tag with an unused data bit set;
    // sender idles often, receiver rarely.
    write_reg(CFG_START_MARKER, 8'($urandom));
    write_reg(CFG_VERSION_MARKER, 8'($urandom));
    write_reg(CFG_TAGGED_TYPE, 8'($urandom));
    write_reg(CFG_TAG_BYTES, {2'b10, 6'd63});
    tx_idle_pct = 53;
    rx_idle_pct = 6;
    queue_random_traffic(30);
    wait_quiet();

    // Phase 3: all-ones and all-zeros markers, no tag; nobody idles.
    write_reg(CFG_START_MARKER, 8'hFF);
    write_reg(CFG_VERSION_MARKER, 8'h00);
    write_reg(CFG_TAGGED_TYPE, 8'h00);
    write_reg(CFG_TAG_BYTES, 8'd0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_traffic(20);
    wait_quiet();

    // Phase 4: opposite extremes, tag of 32 bytes, and a write that hits
    // no register.
    write_reg(CFG_START_MARKER, 8'h00);
    write_reg(CFG_VERSION_MARKER, 8'hFF);
    write_reg(CFG_TAGGED_TYPE, 8'hFF);
    write_reg(CFG_TAG_BYTES, 8'd32);
    write_reg(CFG_UNMAPPED, 8'hA5);
    queue_random_traffic(20);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("crc_framed_message_checker verification clean");
    end else begin
      $display("crc_framed_message_checker verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/crcfm_pkg.sv
hw/rtl/crcfm_crc16.sv
hw/rtl/crcfm_frame.sv
hw/rtl/crc_framed_message_checker.sv
tb/tb_crc_framed_message_checker.sv
